// ----- sv/pmpc_pkg.sv -----
// pmpc_pkg: shared widths, register indexes, reset values and types for the
// pid motor pwm controller. No dependencies.
`default_nettype none

package pmpc_pkg;

  // field and datapath widths
  localparam int SAMPLE_W   = 16;
  localparam int ERR_W      = 18;
  localparam int INTEG_W    = 32;
  localparam int SUM_W      = 33;
  localparam int DPOS_W     = 17;
  localparam int GAIN_W     = 16;
  localparam int PROD_P_W   = 35;
  localparam int PROD_I_W   = 49;
  localparam int PROD_D_W   = 34;
  localparam int DRIVE_W    = 51;
  localparam int DUTY_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // duty saturation limit in percent
  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_MIN  = 3'd4;

  // integrator clamp reset values
  localparam logic signed [INTEG_W-1:0] INTEG_MAX_RST = 32'sd65535;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN_RST = -32'sd65535;

  // per-stage pipeline control
  typedef struct packed {
    logic adv;
    logic vld;
  } stage_ctl_t;

  // loop gains
  typedef struct packed {
    logic [GAIN_W-1:0] prop;
    logic [GAIN_W-1:0] integ;
    logic [GAIN_W-1:0] deriv;
  } gains_t;

endpackage

`default_nettype wire

// ----- sv/pmpc_integ.sv -----
// pmpc_integ: error forming, clamped integrator and position difference stage.
// Depends on pmpc_pkg.
`default_nettype none

module pmpc_integ (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  pmpc_pkg::stage_ctl_t                       ctl,
  input  logic signed [pmpc_pkg::SAMPLE_W-1:0]       tilt,
  input  logic signed [pmpc_pkg::SAMPLE_W-1:0]       position,
  input  logic signed [pmpc_pkg::SAMPLE_W-1:0]       target,
  input  logic signed [pmpc_pkg::INTEG_W-1:0]        integ_max,
  input  logic signed [pmpc_pkg::INTEG_W-1:0]        integ_min,
  output logic signed [pmpc_pkg::ERR_W-1:0]          err_r,
  output logic signed [pmpc_pkg::INTEG_W-1:0]        integ_r,
  output logic signed [pmpc_pkg::DPOS_W-1:0]         dpos_r
);
  import pmpc_pkg::*;

  logic signed [ERR_W-1:0]    err;
  logic signed [SUM_W-1:0]    sum;
  logic signed [INTEG_W-1:0]  integ_nxt;
  logic signed [DPOS_W-1:0]   dpos;
  logic signed [SAMPLE_W-1:0] last_pos_r;

  // combined error and position step
  assign err  = ERR_W'(tilt) + ERR_W'(target) - ERR_W'(position);
  assign dpos = DPOS_W'(last_pos_r) - DPOS_W'(position);
  assign sum  = SUM_W'(integ_r) + SUM_W'(err);

  // clamp, upper bound checked first
  always_comb begin
    priority if (sum > SUM_W'(integ_max)) begin
      integ_nxt = integ_max;
    end else if (sum < SUM_W'(integ_min)) begin
      integ_nxt = integ_min;
    end else begin
      integ_nxt = sum[INTEG_W-1:0];
    end
  end

  // loop state, updated once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      last_pos_r <= '0;
    end else if (ctl.adv && ctl.vld) begin
      integ_r    <= integ_nxt;
      last_pos_r <= position;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (ctl.adv && ctl.vld) begin
      err_r  <= err;
      dpos_r <= dpos;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pmpc_mult.sv -----
// pmpc_mult: the three gain products, each registered.
// Depends on pmpc_pkg.
`default_nettype none

module pmpc_mult (
  input  logic                                  clk,
  input  pmpc_pkg::stage_ctl_t                  ctl,
  input  pmpc_pkg::gains_t                      gains,
  input  logic signed [pmpc_pkg::ERR_W-1:0]     err,
  input  logic signed [pmpc_pkg::INTEG_W-1:0]   integ,
  input  logic signed [pmpc_pkg::DPOS_W-1:0]    dpos,
  output logic signed [pmpc_pkg::PROD_P_W-1:0]  prod_p_r,
  output logic signed [pmpc_pkg::PROD_I_W-1:0]  prod_i_r,
  output logic signed [pmpc_pkg::PROD_D_W-1:0]  prod_d_r
);
  import pmpc_pkg::*;

  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;

  // gains are unsigned, widen with a zero sign bit
  assign prod_p = PROD_P_W'($signed({1'b0, gains.prop}))  * PROD_P_W'(err);
  assign prod_i = PROD_I_W'($signed({1'b0, gains.integ})) * PROD_I_W'(integ);
  assign prod_d = PROD_D_W'($signed({1'b0, gains.deriv})) * PROD_D_W'(dpos);

  always_ff @(posedge clk) begin
    if (ctl.adv && ctl.vld) begin
      prod_p_r <= prod_p;
      prod_i_r <= prod_i;
      prod_d_r <= prod_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pmpc_duty.sv -----
// pmpc_duty: drive sum, saturation to percent and forward/reverse steering.
// Depends on pmpc_pkg.
`default_nettype none

module pmpc_duty (
  input  logic                                  clk,
  input  pmpc_pkg::stage_ctl_t                  ctl,
  input  logic signed [pmpc_pkg::PROD_P_W-1:0]  prod_p,
  input  logic signed [pmpc_pkg::PROD_I_W-1:0]  prod_i,
  input  logic signed [pmpc_pkg::PROD_D_W-1:0]  prod_d,
  output logic [pmpc_pkg::DUTY_W-1:0]           pwm_fwd_r,
  output logic [pmpc_pkg::DUTY_W-1:0]           pwm_rev_r
);
  import pmpc_pkg::*;

  logic signed [DRIVE_W-1:0] drive;
  logic signed [DRIVE_W-1:0] lim;
  logic [7:0]                neg_lo;
  logic [DUTY_W-1:0]         fwd_nxt;
  logic [DUTY_W-1:0]         rev_nxt;

  assign drive  = DRIVE_W'(prod_p) + DRIVE_W'(prod_i) + DRIVE_W'(prod_d);
  assign lim    = $signed(DRIVE_W'(DUTY_MAX));
  assign neg_lo = 8'd0 - drive[7:0];

  // saturate magnitude, zero drive goes to reverse as zero
  always_comb begin
    fwd_nxt = '0;
    rev_nxt = '0;
    priority if (drive > lim) begin
      fwd_nxt = DUTY_MAX;
    end else if (drive > DRIVE_W'(0)) begin
      fwd_nxt = drive[DUTY_W-1:0];
    end else if (drive < -lim) begin
      rev_nxt = DUTY_MAX;
    end else begin
      rev_nxt = neg_lo[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv && ctl.vld) begin
      pwm_fwd_r <= fwd_nxt;
      pwm_rev_r <= rev_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pid_motor_pwm_controller_unit.sv -----
// pid_motor_pwm_controller_unit: top level, config registers, input register
// and pipeline valids. Depends on pmpc_pkg, pmpc_integ, pmpc_mult, pmpc_duty.
//
// usage
//   input channel in_valid/in_ready carries one sample word (tilt, position,
//   target); output channel out_valid/out_ready carries one duty word
//   (pwm_forward, pwm_reverse) per sample, in order.
//   cfg_we/cfg_index/cfg_wdata writes a gain or clamp register;
//   write only while no sample is in flight. Unused indexes are ignored.
// timing
//   four pipeline stages: input register, error and clamped integrator,
//   gain products, drive sum and saturation into the output register.
//   An accepted word moves through the stage registers in order to out_valid.
//   One word per cycle sustained while out_ready keeps up; the integrator loop
//   closes inside the second stage, so consecutive samples need no spacing.
// reset
//   synchronous active-low rst_n empties the pipeline, zeroes the integrator
//   and last position, and loads the register reset values.
// stalls
//   while the output word waits on out_ready the whole pipeline holds and
//   in_ready drops; it resumes the cycle the word is taken.
`default_nettype none

module pid_motor_pwm_controller_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [pmpc_pkg::SAMPLE_W-1:0]   in_tilt,
  input  logic signed [pmpc_pkg::SAMPLE_W-1:0]   in_position,
  input  logic signed [pmpc_pkg::SAMPLE_W-1:0]   in_target,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [pmpc_pkg::DUTY_W-1:0]            out_pwm_forward,
  output logic [pmpc_pkg::DUTY_W-1:0]            out_pwm_reverse,
  input  logic                                   cfg_we,
  input  logic [pmpc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pmpc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import pmpc_pkg::*;

  gains_t                     gains_r;
  logic signed [INTEG_W-1:0]  integ_max_r;
  logic signed [INTEG_W-1:0]  integ_min_r;

  logic                       adv;
  logic                       v1_r;
  logic                       v2_r;
  logic                       v3_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] tilt_r;
  logic signed [SAMPLE_W-1:0] pos_r;
  logic signed [SAMPLE_W-1:0] target_r;

  stage_ctl_t                 ctl_integ;
  stage_ctl_t                 ctl_mult;
  stage_ctl_t                 ctl_duty;

  logic signed [ERR_W-1:0]    err;
  logic signed [INTEG_W-1:0]  integ;
  logic signed [DPOS_W-1:0]   dpos;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r     <= '0;
      integ_max_r <= INTEG_MAX_RST;
      integ_min_r <= INTEG_MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  gains_r.prop  <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_GAIN: gains_r.integ <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN: gains_r.deriv <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_MAX:  integ_max_r   <= $signed(cfg_wdata[INTEG_W-1:0]);
        REG_INTEG_MIN:  integ_min_r   <= $signed(cfg_wdata[INTEG_W-1:0]);
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the output word is stalled
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      tilt_r   <= in_tilt;
      pos_r    <= in_position;
      target_r <= in_target;
    end
  end

  assign ctl_integ = '{adv: adv, vld: v1_r};
  assign ctl_mult  = '{adv: adv, vld: v2_r};
  assign ctl_duty  = '{adv: adv, vld: v3_r};

  pmpc_integ u_integ (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_integ),
    .tilt      (tilt_r),
    .position  (pos_r),
    .target    (target_r),
    .integ_max (integ_max_r),
    .integ_min (integ_min_r),
    .err_r     (err),
    .integ_r   (integ),
    .dpos_r    (dpos)
  );

  pmpc_mult u_mult (
    .clk      (clk),
    .ctl      (ctl_mult),
    .gains    (gains_r),
    .err      (err),
    .integ    (integ),
    .dpos     (dpos),
    .prod_p_r (prod_p),
    .prod_i_r (prod_i),
    .prod_d_r (prod_d)
  );

  pmpc_duty u_duty (
    .clk       (clk),
    .ctl       (ctl_duty),
    .prod_p    (prod_p),
    .prod_i    (prod_i),
    .prod_d    (prod_d),
    .pwm_fwd_r (out_pwm_forward),
    .pwm_rev_r (out_pwm_reverse)
  );

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- sv/pmpc_checker.sv -----
// pmpc_checker: port-level checks on the pid motor pwm controller, bound to
// the top level. Depends on pmpc_pkg and pid_motor_pwm_controller_unit.
`default_nettype none

module pmpc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [pmpc_pkg::DUTY_W-1:0]   out_pwm_forward,
  input  logic [pmpc_pkg::DUTY_W-1:0]   out_pwm_reverse
);
  import pmpc_pkg::*;

  // pipeline empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pwm_forward)
      && $stable(out_pwm_reverse))
    else $error("stalled output word changed");

  // a stalled output blocks new input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // only one direction driven
  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pwm_forward == '0 || out_pwm_reverse == '0)
    else $error("both pwm outputs nonzero");

  // duty within limit
  a_duty_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pwm_forward <= DUTY_MAX && out_pwm_reverse <= DUTY_MAX)
    else $error("duty above limit");

endmodule

bind pid_motor_pwm_controller_unit pmpc_checker u_pmpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pwm_forward (out_pwm_forward),
  .out_pwm_reverse (out_pwm_reverse)
);

`default_nettype wire

// ----- bench/pid_motor_pwm_controller_unit_test.sv -----
// pid_motor_pwm_controller_unit_test: self-checking bench for the pid motor pwm
// controller; a directed table, then random config phases with bursty sample
// words and a stalling sink. Depends on pmpc_pkg and pid_motor_pwm_controller_unit.
module pid_motor_pwm_controller_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pmpc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_WORDS  = 500;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 12;
  localparam int REPORT_LIMIT  = 10;
  localparam int DIRECTED_ROWS = 35;

  // register indexes past the end of the list, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_INTEG_MIN + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] tilt;
    logic signed [SAMPLE_W-1:0] position;
    logic signed [SAMPLE_W-1:0] target;
  } sample_t;

  typedef struct packed {
    logic [DUTY_W-1:0] fwd;
    logic [DUTY_W-1:0] rev;
  } duty_t;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    sample_t                word;
    logic                   typed;
    duty_t                  duty;
  } row_t;

  typedef enum int {FIELD_NARROW, FIELD_FULL, FIELD_EXTREME} field_style_t;
  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_SPARSE} sink_mode_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [SAMPLE_W-1:0] in_tilt = '0;
  logic signed [SAMPLE_W-1:0] in_position = '0;
  logic signed [SAMPLE_W-1:0] in_target = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [DUTY_W-1:0]         out_pwm_forward;
  logic [DUTY_W-1:0]         out_pwm_reverse;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata = '0;

  // predictor copy of the gains, clamps and loop state
  logic [GAIN_W-1:0]         gain_p = '0;
  logic [GAIN_W-1:0]         gain_i = '0;
  logic [GAIN_W-1:0]         gain_d = '0;
  longint                    clamp_hi = longint'(INTEG_MAX_RST);
  longint                    clamp_lo = longint'(INTEG_MIN_RST);
  longint                    integ_acc = 0;
  logic signed [SAMPLE_W-1:0] prev_pos = '0;

  duty_t                     pending_duties[$];
  int                        mismatch_count = 0;
  int                        cycle_count = 0;
  int                        burst_left = 0;

  // sink stall control
  logic                      hold_req = 1'b0;
  bit                        hold_done = 1'b0;
  int                        hold_left = 0;
  int                        mode_left = 0;
  sink_mode_t                sink_mode = SINK_OPEN;

  pid_motor_pwm_controller_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_tilt         (in_tilt),
    .in_position     (in_position),
    .in_target       (in_target),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pwm_forward (out_pwm_forward),
    .out_pwm_reverse (out_pwm_reverse),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // directed table entries
  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic row_t word_row(input int t, input int p, input int g);
    row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.word.tilt = SAMPLE_W'(t);
    r.word.position = SAMPLE_W'(p);
    r.word.target = SAMPLE_W'(g);
    return r;
  endfunction

  function automatic row_t typed_row(input int t, input int p, input int g,
                                     input int f, input int v);
    row_t r;
    r = word_row(t, p, g);
    r.typed = 1'b1;
    r.duty.fwd = DUTY_W'(f);
    r.duty.rev = DUTY_W'(v);
    return r;
  endfunction

  row_t directed_rows [DIRECTED_ROWS] = '{
    // after reset all gains are zero, so the drive is zero
    typed_row(0, 0, 0, 0, 0),
    typed_row(32767, -32768, 32767, 0, 0),
    typed_row(-32768, 32767, -32768, 0, 0),
    // unit proportional gain, small errors pass straight through
    cfg_row(REG_PROP_GAIN, 32'd1),
    typed_row(7, 0, 0, 7, 0),
    typed_row(-9, 0, 0, 0, 9),
    typed_row(0, 5, 5, 0, 0),
    // full proportional gain on the largest errors saturates
    cfg_row(REG_PROP_GAIN, 32'h0000_FFFF),
    typed_row(32767, -32768, 32767, 100, 0),
    typed_row(-32768, 32767, -32768, 0, 100),
    // crossed clamps, upper test wins
    cfg_row(REG_PROP_GAIN, 32'd0),
    cfg_row(REG_INTEG_GAIN, 32'd1),
    cfg_row(REG_INTEG_MAX, 32'hFFFF_FFF6),
    cfg_row(REG_INTEG_MIN, 32'd10),
    word_row(100, 0, 0),
    word_row(-200, 0, 0),
    word_row(0, 0, 0),
    // integrator pinned near the top rail, sum overflows 32 bits
    cfg_row(REG_INTEG_GAIN, 32'h0000_FFFF),
    cfg_row(REG_INTEG_MAX, 32'h7FFF_FFFF),
    cfg_row(REG_INTEG_MIN, 32'h7FFF_0000),
    word_row(32767, -32768, 32767),
    word_row(32767, -32768, 32767),
    // and near the bottom rail
    cfg_row(REG_INTEG_MIN, 32'h8000_0000),
    cfg_row(REG_INTEG_MAX, 32'h8000_FFFF),
    word_row(-32768, 32767, -32768),
    word_row(-32768, 32767, -32768),
    // derivative term alone, full and unit gain
    cfg_row(REG_INTEG_GAIN, 32'd0),
    cfg_row(REG_DERIV_GAIN, 32'h0000_FFFF),
    word_row(0, 32767, 0),
    word_row(0, -32768, 0),
    cfg_row(REG_DERIV_GAIN, 32'd1),
    word_row(0, -32700, 0),
    // writes past the register list must not disturb anything
    cfg_row(REG_SPARE_FIRST, 32'hFFFF_FFFF),
    cfg_row(REG_SPARE_LAST, 32'hFFFF_FFFF),
    word_row(0, -32690, 0)
  };

  // next duty word of the controller, advances integrator and last position
  function automatic duty_t duty_for_sample(input sample_t s);
    longint err;
    longint acc;
    longint drive;
    longint mag;
    duty_t d;
    err = longint'($signed(s.tilt)) + longint'($signed(s.target))
        - longint'($signed(s.position));
    acc = integ_acc + err;
    if (acc > clamp_hi) begin
      acc = clamp_hi;
    end else if (acc < clamp_lo) begin
      acc = clamp_lo;
    end
    integ_acc = acc;
    drive = longint'(gain_p) * err + longint'(gain_i) * integ_acc
          + longint'(gain_d) * (longint'(prev_pos) - longint'($signed(s.position)));
    prev_pos = s.position;
    mag = (drive < 0) ? -drive : drive;
    if (mag > longint'(DUTY_MAX)) begin
      mag = longint'(DUTY_MAX);
    end
    d.fwd = (drive > 0) ? mag[DUTY_W-1:0] : '0;
    d.rev = (drive > 0) ? '0 : mag[DUTY_W-1:0];
    return d;
  endfunction

  // sender burst shaping: zero inside a burst, a short gap between bursts
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
    return $urandom_range(1, 6);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_field(input field_style_t main_style);
    field_style_t st;
    st = ($urandom_range(0, 3) == 0) ? field_style_t'($urandom_range(0, 2)) : main_style;
    case (st)
      FIELD_NARROW: return SAMPLE_W'(int'($urandom_range(0, 120)) - 60);
      FIELD_FULL:   return SAMPLE_W'($urandom_range(0, 65535));
      default: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return -16'sd1;
          3:       return 16'sd1;
          default: return 16'sd0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] draw_gain();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return GAIN_W'($urandom_range(0, 3));
      4, 5:       return GAIN_W'($urandom_range(0, 255));
      6:          return '0;
      7:          return '1;
      default:    return GAIN_W'($urandom);
    endcase
  endfunction

  // register write while the pipeline is empty
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_PROP_GAIN:  gain_p = data[GAIN_W-1:0];
      REG_INTEG_GAIN: gain_i = data[GAIN_W-1:0];
      REG_DERIV_GAIN: gain_d = data[GAIN_W-1:0];
      REG_INTEG_MAX:  clamp_hi = longint'($signed(data));
      REG_INTEG_MIN:  clamp_lo = longint'($signed(data));
      default: ;
    endcase
  endtask

  // offer one sample word, log its duty once taken, then maybe pause
  task automatic send_sample(input sample_t s, input logic typed, input duty_t typed_duty);
    duty_t d;
    int gap;
    cfg_we <= 1'b0;
    in_valid <= 1'b1;
    in_tilt <= s.tilt;
    in_position <= s.position;
    in_target <= s.target;
    do @(posedge clk); while (!in_ready);
    d = duty_for_sample(s);
    pending_duties.push_back(typed ? typed_duty : d);
    gap = next_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // new random gains and clamps for a phase
  task automatic pick_settings();
    logic [CFG_DATA_W-1:0] hi;
    logic [CFG_DATA_W-1:0] lo;
    if ($urandom_range(0, 9) < 7) cfg_write(REG_PROP_GAIN, {16'($urandom), draw_gain()});
    if ($urandom_range(0, 9) < 7) cfg_write(REG_INTEG_GAIN, {16'($urandom), draw_gain()});
    if ($urandom_range(0, 9) < 7) cfg_write(REG_DERIV_GAIN, {16'($urandom), draw_gain()});
    case ($urandom_range(0, 6))
      0: begin
        hi = INTEG_MAX_RST;
        lo = INTEG_MIN_RST;
      end
      1: begin
        hi = $urandom_range(0, 2000);
        lo = -hi;
      end
      2: begin
        hi = 32'h7FFF_FFFF;
        lo = 32'h8000_0000;
      end
      3: begin
        hi = 32'h7FFF_FFFF;
        lo = 32'h7FFF_FFFF - $urandom_range(0, 200000);
      end
      4: begin
        lo = 32'h8000_0000;
        hi = 32'h8000_0000 + $urandom_range(0, 200000);
      end
      5: begin
        hi = 32'd0 - $urandom_range(0, 500);
        lo = $urandom_range(0, 500);
      end
      default: begin
        hi = $urandom;
        lo = $urandom;
      end
    endcase
    if ($urandom_range(0, 1) == 0) begin
      cfg_write(REG_INTEG_MAX, hi);
      cfg_write(REG_INTEG_MIN, lo);
    end else begin
      cfg_write(REG_INTEG_MIN, lo);
      cfg_write(REG_INTEG_MAX, hi);
    end
    if ($urandom_range(0, 7) == 0) begin
      cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom);
    end
  endtask

  // sink: open, random and sparse stretches, plus one long hold on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        sink_mode <= sink_mode_t'($urandom_range(0, 2));
        mode_left <= $urandom_range(8, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (sink_mode)
        SINK_OPEN:   out_ready <= 1'b1;
        SINK_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default:     out_ready <= (cycle_count[1:0] == 2'b00);
      endcase
    end
  end

  // duty word check against the oldest expectation
  always @(posedge clk) begin : duty_check
    duty_t exp_duty;
    if (rst_n && out_valid && out_ready) begin
      if (pending_duties.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected duty word: fwd %0d rev %0d", out_pwm_forward, out_pwm_reverse);
        end
      end else begin
        exp_duty = pending_duties.pop_front();
        if (out_pwm_forward !== exp_duty.fwd || out_pwm_reverse !== exp_duty.rev) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("duty mismatch: fwd exp %0d got %0d, rev exp %0d got %0d",
                     exp_duty.fwd, out_pwm_forward, exp_duty.rev, out_pwm_reverse);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    sample_t s;
    field_style_t phase_style;
    int words_sent;
    int phase_idx;
    int phase_len;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        cfg_write(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_sample(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].duty);
      end
    end

    // random phases, one settings change per phase
    words_sent = 0;
    phase_idx = 0;
    while (words_sent < RANDOM_WORDS) begin
      pick_settings();
      phase_len = $urandom_range(20, 80);
      phase_style = field_style_t'($urandom_range(0, 2));
      for (int k = 0; k < phase_len && words_sent < RANDOM_WORDS; k++) begin
        s.tilt = draw_field(phase_style);
        s.position = draw_field(phase_style);
        s.target = draw_field(phase_style);
        send_sample(s, 1'b0, '0);
        words_sent++;
        // mid-phase, ask the sink for a long hold so the pipeline backs up
        if (phase_idx == 1 && k == 10) hold_req <= 1'b1;
      end
      phase_idx++;
    end

    // drain
    in_valid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
